// ----- rtl/core/mdio_management_master_assert.svh -----
// assertion macros for the mdio management master
`ifndef MDIO_MANAGEMENT_MASTER_ASSERT_SVH
`define MDIO_MANAGEMENT_MASTER_ASSERT_SVH

`ifndef ASSERT_OFF
`define MDM_ASSERT_IMP(label, clk, rst_n, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error("mdm assertion failed");
`define MDM_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error("mdm assertion failed");
`else
`define MDM_ASSERT_IMP(label, clk, rst_n, cond, prop)
`define MDM_ASSERT_NEXT(label, clk, rst_n, cond, prop)
`endif

`endif

// ----- rtl/core/mdm_pkg.sv -----
// shared types and frame constants for the mdio management master
package mdm_pkg;

  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_READ  = 2'd1;
  localparam logic [1:0] ACT_WRITE = 2'd2;

  localparam logic [3:0] OP_READ  = 4'h6;
  localparam logic [3:0] OP_WRITE = 4'h5;
  localparam logic [1:0] TA_WRITE = 2'h2;

  localparam int SEND_BITS = 32;
  localparam int DATA_BITS = 16;

  typedef struct packed {
    logic [1:0]           action;
    logic [4:0]           phy_addr;
    logic [4:0]           reg_addr;
    logic [DATA_BITS-1:0] write_data;
    logic                 mdio_in;
  } mdm_item_t;

  typedef struct packed {
    logic                 mdc_pulse;
    logic                 mdio_out;
    logic                 mdio_drive;
    logic                 busy;
    logic                 done;
    logic [DATA_BITS-1:0] read_data;
    logic                 rejected;
  } mdm_result_t;

endpackage

// ----- rtl/core/mdio_management_master.sv -----
// top level of the clause 22 mdio management master
//
// slave side: one transaction per mdc bit period or command. in_tuser holds
// the action (tick, start read, start write); in_tdata holds phy address,
// register address, write data and the sampled mdio pin level.
// master side: one result transaction per input transaction with the mdc
// pulse flag, mdio level and drive enable, busy, read data and the rejected
// flag; out_tlast marks the last bit period of a frame.
// a read frame takes PREAMBLE_BITS+31 ticks, a write PREAMBLE_BITS+32, after
// the start transaction; a start while a frame runs is rejected.
// a transaction passes an input register, then the frame sequencer logic into
// the result register. one transaction is taken every cycle unless the result
// side stalls; the counter and shift registers update once per transaction.
// reset clears the stages and returns the sequencer to idle with mdio released.
// when out_tready is low the result register holds, the input register still
// takes one transaction, and in_tready then drops until the result is taken.
`include "mdio_management_master_assert.svh"

module mdio_management_master
  import mdm_pkg::*;
#(
  parameter int PREAMBLE_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // phy_addr, reg_addr, write_data, mdio_in, zero fill
  input  logic [1:0]  in_tuser,   // action
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // mdc_pulse, mdio_out, mdio_drive, busy_res,
                                  // read_data, rejected, zero fill
  output logic        out_tlast
);

  logic        s1_valid_r;
  mdm_item_t   s1_item_r;
  logic        can_load;
  logic        adv;
  mdm_result_t eng_res;
  mdm_result_t out_res;

  assign adv       = s1_valid_r && can_load;
  assign in_tready = !s1_valid_r || can_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_item_r.action     <= in_tuser;
      s1_item_r.phy_addr   <= in_tdata[4:0];
      s1_item_r.reg_addr   <= in_tdata[9:5];
      s1_item_r.write_data <= in_tdata[25:10];
      s1_item_r.mdio_in    <= in_tdata[26];
    end
  end

  mdm_frame_engine #(
    .PREAMBLE_BITS(PREAMBLE_BITS)
  ) u_engine (
    .clk  (clk),
    .rst_n(rst_n),
    .adv  (adv),
    .item (s1_item_r),
    .res  (eng_res)
  );

  mdm_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load_valid(s1_valid_r),
    .load_data (eng_res),
    .can_load  (can_load),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_res)
  );

  assign out_tdata = {3'b000, out_res.rejected, out_res.read_data, out_res.busy,
                      out_res.mdio_drive, out_res.mdio_out, out_res.mdc_pulse};
  assign out_tlast = out_res.done;

  `MDM_ASSERT_IMP(a_stall_only_downstream, clk, rst_n, !in_tready,
                  out_tvalid && !out_tready)
  `MDM_ASSERT_IMP(a_released_low, clk, rst_n, out_tvalid && !out_tdata[2],
                  !out_tdata[1])
  `MDM_ASSERT_IMP(a_done_in_frame, clk, rst_n, out_tvalid && out_tlast,
                  out_tdata[0] && out_tdata[3])
  `MDM_ASSERT_IMP(a_reject_quiet, clk, rst_n, out_tvalid && out_tdata[20],
                  !out_tdata[0] && !out_tdata[2] && out_tdata[3])

endmodule

// ----- rtl/core/mdm_frame_engine.sv -----
// frame sequencer: period counter, send and receive shift registers
module mdm_frame_engine
  import mdm_pkg::*;
#(
  parameter int PREAMBLE_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        adv,
  input  mdm_item_t   item,
  output mdm_result_t res
);

  localparam int CNT_W = $clog2(PREAMBLE_BITS + 32);
  localparam logic [CNT_W-1:0] PRE     = CNT_W'(PREAMBLE_BITS);
  localparam logic [CNT_W-1:0] TA_RD   = CNT_W'(PREAMBLE_BITS + 14);
  localparam logic [CNT_W-1:0] DATA_RD = CNT_W'(PREAMBLE_BITS + 15);
  localparam logic [CNT_W-1:0] LAST_RD = CNT_W'(PREAMBLE_BITS + 30);
  localparam logic [CNT_W-1:0] LAST_WR = CNT_W'(PREAMBLE_BITS + 31);

  logic                 active_r, active_nxt;
  logic                 op_rd_r, op_rd_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [SEND_BITS-1:0] tx_r, tx_nxt;
  logic [DATA_BITS-1:0] rx_r, rx_nxt;
  logic [CNT_W-1:0]     last;
  logic                 done;

  assign last = op_rd_r ? LAST_RD : LAST_WR;
  assign done = (cnt_r >= last);

  always_comb begin
    active_nxt     = active_r;
    op_rd_nxt      = op_rd_r;
    cnt_nxt        = cnt_r;
    tx_nxt         = tx_r;
    rx_nxt         = rx_r;
    res.mdc_pulse  = 1'b0;
    res.mdio_out   = 1'b0;
    res.mdio_drive = 1'b0;
    res.busy       = active_r;
    res.done       = 1'b0;
    res.rejected   = 1'b0;
    unique case (item.action)
      ACT_READ, ACT_WRITE: begin
        if (active_r) begin
          res.rejected = 1'b1;
        end else begin
          op_rd_nxt = (item.action == ACT_READ);
          if (item.action == ACT_READ) begin
            tx_nxt = {OP_READ, item.phy_addr, item.reg_addr, 18'd0};
          end else begin
            tx_nxt = {OP_WRITE, item.phy_addr, item.reg_addr, TA_WRITE, item.write_data};
          end
          rx_nxt         = '0;
          cnt_nxt        = '0;
          active_nxt     = 1'b1;
          res.mdio_drive = 1'b1;
          res.busy       = 1'b1;
        end
      end
      ACT_TICK: begin
        if (active_r) begin
          res.mdc_pulse = 1'b1;
          res.done      = done;
          priority if (cnt_r < PRE) begin
            res.mdio_out   = 1'b1;
            res.mdio_drive = 1'b1;
          end else if (op_rd_r && cnt_r >= TA_RD) begin
            if (cnt_r >= DATA_RD) begin
              rx_nxt = {rx_r[DATA_BITS-2:0], item.mdio_in};
            end
          end else begin
            res.mdio_out   = tx_r[SEND_BITS-1];
            res.mdio_drive = 1'b1;
            tx_nxt         = {tx_r[SEND_BITS-2:0], 1'b0};
          end
          if (done) begin
            active_nxt = 1'b0;
            cnt_nxt    = '0;
          end else begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
    res.read_data = rx_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      op_rd_r  <= 1'b0;
      cnt_r    <= '0;
      tx_r     <= '0;
      rx_r     <= '0;
    end else if (adv) begin
      active_r <= active_nxt;
      op_rd_r  <= op_rd_nxt;
      cnt_r    <= cnt_nxt;
      tx_r     <= tx_nxt;
      rx_r     <= rx_nxt;
    end
  end

endmodule

// ----- rtl/core/mdm_out_stage.sv -----
// result register toward the master-side stream
module mdm_out_stage
  import mdm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        load_valid,
  input  mdm_result_t load_data,
  output logic        can_load,
  output logic        out_valid,
  input  logic        out_ready,
  output mdm_result_t out_data
);

  logic        valid_r;
  mdm_result_t data_r;

  assign can_load  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (can_load) begin
      valid_r <= load_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (can_load && load_valid) begin
      data_r <= load_data;
    end
  end

endmodule

// ----- sim/mdio_period_checker.sv -----
`timescale 1ns / 100ps
// checker for the mdio management master: predicts the result of every transaction and compares results
module mdio_period_checker
  import mdm_pkg::*;
#(
  parameter int PREAMBLE = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,
  input  logic [1:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [23:0] out_tdata,
  input  logic        out_tlast,
  output int          failures,
  output int          outstanding
);

  logic        frame_on;
  logic        is_read;
  logic [6:0]  period;
  logic [31:0] tx_shift;
  logic [15:0] rx_shift;
  int          fail_count;
  int          result_index;

  mdm_result_t expected_periods[$];

  task automatic predict_period(input logic [1:0] act, input logic [31:0] data,
                                output mdm_result_t res);
    logic [4:0]  pa;
    logic [4:0]  ra;
    logic [15:0] wd;
    logic        din;
    logic        last;
    pa  = data[4:0];
    ra  = data[9:5];
    wd  = data[25:10];
    din = data[26];
    res = '0;
    if (act == ACT_READ || act == ACT_WRITE) begin
      res.busy = 1'b1;
      if (frame_on) begin
        res.rejected = 1'b1;
      end else begin
        is_read = (act == ACT_READ);
        if (is_read) begin
          tx_shift = {OP_READ, pa, ra, 18'd0};
        end else begin
          tx_shift = {OP_WRITE, pa, ra, TA_WRITE, wd};
        end
        rx_shift = '0;
        period = '0;
        frame_on = 1'b1;
        res.mdio_drive = 1'b1;
      end
    end else if (act == ACT_TICK && frame_on) begin
      last = is_read ? (period >= PREAMBLE + 30) : (period >= PREAMBLE + 31);
      res.mdc_pulse = 1'b1;
      res.busy = 1'b1;
      res.done = last;
      if (period < PREAMBLE) begin
        res.mdio_out = 1'b1;
        res.mdio_drive = 1'b1;
      end else if (is_read && period >= PREAMBLE + 14) begin
        // turnaround, then read data shifted in msb first
        if (period >= PREAMBLE + 15) begin
          rx_shift = {rx_shift[14:0], din};
        end
      end else begin
        res.mdio_out = tx_shift[31];
        res.mdio_drive = 1'b1;
        tx_shift = tx_shift << 1;
      end
      if (last) begin
        frame_on = 1'b0;
        period = '0;
      end else begin
        period = period + 7'd1;
      end
    end else begin
      res.busy = frame_on;
    end
    res.read_data = rx_shift;
  endtask

  always @(posedge clk) begin : watch
    mdm_result_t predicted;
    mdm_result_t wanted;
    mdm_result_t got;
    if (!rst_n) begin
      frame_on = 1'b0;
      is_read = 1'b0;
      period = '0;
      tx_shift = '0;
      rx_shift = '0;
      fail_count = 0;
      result_index = 0;
      expected_periods.delete();
      failures <= 0;
      outstanding <= 0;
    end else begin
      if (in_tvalid && in_tready) begin
        predict_period(in_tuser, in_tdata, predicted);
        expected_periods.push_back(predicted);
      end
      if (out_tvalid && out_tready) begin
        got.mdc_pulse  = out_tdata[0];
        got.mdio_out   = out_tdata[1];
        got.mdio_drive = out_tdata[2];
        got.busy       = out_tdata[3];
        got.read_data  = out_tdata[19:4];
        got.rejected   = out_tdata[20];
        got.done       = out_tlast;
        if (expected_periods.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("result %0d arrived with nothing expected", result_index);
          end
        end else begin
          wanted = expected_periods.pop_front();
          if (got.mdc_pulse !== wanted.mdc_pulse || got.mdio_out !== wanted.mdio_out ||
              got.mdio_drive !== wanted.mdio_drive || got.busy !== wanted.busy ||
              got.done !== wanted.done || got.read_data !== wanted.read_data ||
              got.rejected !== wanted.rejected) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("result %0d: expected mdc %b out %b drv %b busy %b done %b data %h rej %b",
                       result_index, wanted.mdc_pulse, wanted.mdio_out, wanted.mdio_drive,
                       wanted.busy, wanted.done, wanted.read_data, wanted.rejected);
              $display("result %0d: actual   mdc %b out %b drv %b busy %b done %b data %h rej %b",
                       result_index, got.mdc_pulse, got.mdio_out, got.mdio_drive,
                       got.busy, got.done, got.read_data, got.rejected);
            end
          end
        end
        result_index++;
      end
      failures <= fail_count;
      outstanding <= expected_periods.size();
    end
  end

endmodule

// ----- sim/mdio_management_master_test.sv -----
`timescale 1ns / 100ps
// testbench top for the mdio management master: stimulus, flow control and verdict
module mdio_management_master_test;
  import mdm_pkg::*;

  localparam int         PREAMBLE    = 32;
  localparam logic [1:0] ACT_NONE    = 2'd3;
  localparam int         ITEM_TARGET = 1700;
  localparam int         CYCLE_LIMIT = 200000;
  localparam int         HOLD_START  = 1000;
  localparam int         HOLD_CYCLES = 300;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata   = '0;
  logic [1:0]  in_tuser   = ACT_TICK;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic        out_tlast;
  logic        calm       = 1'b0;

  int failures;
  int outstanding;
  int sent;
  int reads_started;
  int writes_started;
  int stray_commands;
  int cycles;
  int rx_cycles;
  int hold_left;

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  mdio_management_master #(
    .PREAMBLE_BITS(PREAMBLE)
  ) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  mdio_period_checker #(
    .PREAMBLE(PREAMBLE)
  ) u_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .failures    (failures),
    .outstanding (outstanding)
  );

  // result side: random stalls, one long hold-off while the sender keeps going
  always @(posedge clk) begin
    rx_cycles++;
    if (rx_cycles == HOLD_START) begin
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= calm || ($urandom_range(99) >= 6);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("mdio_management_master_test failed");
      $finish;
    end
  end

  task automatic send(input logic [1:0] act, input logic [4:0] pa, input logic [4:0] ra,
                      input logic [15:0] wd, input logic din);
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {5'd0, din, wd, ra, pa};
    do @(posedge clk); while (!in_tready);
    sent++;
    while (!calm && $urandom_range(99) < 6) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic tick();
    send(ACT_TICK, 5'($urandom), 5'($urandom), 16'($urandom), 1'($urandom));
  endtask

  // start read or write (rejected while busy) or the unused action code
  task automatic stray_command();
    logic [1:0] act;
    case ($urandom_range(2))
      0:       act = ACT_READ;
      1:       act = ACT_WRITE;
      default: act = ACT_NONE;
    endcase
    stray_commands++;
    send(act, 5'($urandom), 5'($urandom), 16'($urandom), 1'($urandom));
  endtask

  task automatic frame(input logic [1:0] act, input logic [4:0] pa, input logic [4:0] ra,
                       input logic [15:0] wd, input int noise_pct);
    int periods;
    periods = (act == ACT_READ) ? PREAMBLE + 31 : PREAMBLE + 32;
    if (act == ACT_READ) begin
      reads_started++;
    end else begin
      writes_started++;
    end
    send(act, pa, ra, wd, 1'($urandom));
    for (int i = 0; i < periods; i++) begin
      while ($urandom_range(99) < noise_pct) begin
        stray_command();
      end
      tick();
    end
  endtask

  initial begin : stimulus
    int pick;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // idle behavior, extremes of the fields, back-to-back frames
    send(ACT_TICK, 5'd31, 5'd31, 16'hffff, 1'b1);
    send(ACT_NONE, 5'd31, 5'd31, 16'hffff, 1'b1);
    frame(ACT_READ, 5'd31, 5'd0, 16'hffff, 0);
    frame(ACT_WRITE, 5'd0, 5'd31, 16'hffff, 0);
    frame(ACT_WRITE, 5'd21, 5'd10, 16'h0000, 0);
    frame(ACT_READ, 5'd10, 5'd21, 16'h0000, 20);
    send(ACT_NONE, 5'd0, 5'd0, 16'h0000, 1'b0);

    while (sent < ITEM_TARGET) begin
      calm <= (sent >= 1200 && sent < 1500);
      pick = $urandom_range(99);
      if (pick < 85) begin
        frame($urandom_range(1) ? ACT_READ : ACT_WRITE, 5'($urandom), 5'($urandom),
              16'($urandom), 3);
      end else if (pick < 93) begin
        repeat ($urandom_range(3, 1)) tick();
      end else begin
        stray_command();
      end
    end
    in_tvalid <= 1'b0;

    do @(posedge clk); while (outstanding != 0);
    repeat (8) @(posedge clk);

    $display("ran %0d transactions: %0d read and %0d write frames, %0d stray commands",
             sent, reads_started, writes_started, stray_commands);
    $display("including a %0d cycle result hold-off and a stretch with no idling",
             HOLD_CYCLES);
    if (failures == 0 && outstanding == 0) begin
      $display("mdio_management_master_test passed");
    end else begin
      $display("%0d mismatches", failures);
      $display("mdio_management_master_test failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/mdm_pkg.sv
rtl/core/mdm_frame_engine.sv
rtl/core/mdm_out_stage.sv
rtl/core/mdio_management_master.sv
sim/mdio_period_checker.sv
sim/mdio_management_master_test.sv
